[sv/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// checked outside reset only
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");
// checked on every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");
`else
`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[sv/kt_pkg.sv]
package kt_pkg;

  localparam int CAPACITY      = 128;
  localparam int VALUE_BITS    = 64;
  localparam int ID_BITS       = 32;
  localparam int PORT_VAL_BITS = 64;
  localparam int CFG_BITS      = 8;
  localparam int CNT_W         = $clog2(CAPACITY + 1);
  localparam int IDX_W         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int ENTRY_W       = ID_BITS + VALUE_BITS;
  localparam int MAX_RESET     = (CAPACITY < 128) ? CAPACITY : 128;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DELETE = 2'd1,
    OP_UPDATE = 2'd2,
    OP_GET    = 2'd3
  } kt_op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_DUP     = 2'd2,
    ST_MISSING = 2'd3
  } kt_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } kt_state_e;

  typedef struct packed {
    kt_op_e                    op;
    logic signed [ID_BITS-1:0] key;
    logic signed [ID_BITS-1:0] entry_id;
    logic [PORT_VAL_BITS-1:0]  entry_value;
  } kt_in_t;

  typedef struct packed {
    kt_status_e                status;
    logic signed [ID_BITS-1:0] found_id;
    logic [PORT_VAL_BITS-1:0]  found_value;
  } kt_out_t;

endpackage

[sv/kt_ram.sv]
module kt_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/keyed_entry_table.sv]
// Keyed entry table: an ordered list of (id, value) entries kept in one RAM.
// Input channel in_valid_i/in_stall_o carries a request word: add, delete,
// update or get. Output channel out_valid_o/out_stall_i returns one result
// word per request: status, plus the found entry for a successful get.
// cfg_we_i/cfg_wdata_i set the capacity in use (saturates at CAPACITY).
// Operation, with n the current entry count: one RAM read per cycle, so a
// search walks the n entries in order; a delete that hits then moves the
// later entries down through the same port before the result is registered.
// An add to a full table skips the search and goes straight to its result.
// One request is in flight at a time; the next is taken once the result is
// registered, even if still stalled. Reset empties the table (count to zero,
// capacity min(128, CAPACITY)); RAM contents are left as they are. While the
// receiver stalls, the result word holds and a finished request waits in its
// last state.
module keyed_entry_table (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  kt_pkg::kt_in_t       in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output kt_pkg::kt_out_t      out_word_o,
  input  logic                 cfg_we_i,
  input  logic [kt_pkg::CFG_BITS-1:0] cfg_wdata_i
);
  import kt_pkg::*;

`include "assert_macros.svh"

  kt_state_e state_q, state_d;

  kt_in_t               req_q, req_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     cap_q, cap_d;
  logic [CNT_W-1:0]     rd_idx_q, rd_idx_d;
  logic                 cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]     cmp_idx_q, cmp_idx_d;
  logic                 full_q, full_d;
  logic                 key_found_q, key_found_d;
  logic [IDX_W-1:0]     key_idx_q, key_idx_d;
  logic                 nid_any_q, nid_any_d;
  logic                 clash_q, clash_d;
  logic [ENTRY_W-1:0]   hit_q, hit_d;
  logic                 out_valid_q, out_valid_d;
  kt_out_t              out_word_q, out_word_d;

  logic                 accept;
  logic                 issue;
  logic                 walk_end;
  logic                 load;
  kt_status_e           status;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [ENTRY_W-1:0]   ram_rdata;
  logic [ID_BITS-1:0]   rd_id;
  logic                 key_hit;
  logic                 nid_hit;
  logic                 first_hit;
  logic [ENTRY_W-1:0]   new_entry;

  kt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(rd_idx_q[IDX_W-1:0]),
    .rdata_o(ram_rdata)
  );

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign walk_end = (rd_idx_q >= count_q);
  assign issue    = ((state_q == S_SCAN) || (state_q == S_SHIFT)) && !walk_end;
  assign load     = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // shared compare unit: one stored id against key and new id
  assign rd_id     = ram_rdata[ENTRY_W-1 -: ID_BITS];
  assign key_hit   = cmp_vld_q && (rd_id == req_q.key);
  assign nid_hit   = cmp_vld_q && (rd_id == req_q.entry_id);
  assign first_hit = key_hit && !key_found_q;
  assign new_entry = {req_q.entry_id, req_q.entry_value[VALUE_BITS-1:0]};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if ((in_word_i.op == OP_ADD) && (count_q >= cap_q)) begin
            state_d = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (walk_end) begin
          // the final compare lands this edge, so test its hit too
          if ((req_q.op == OP_DELETE) && (key_found_q || first_hit)) begin
            state_d = S_SHIFT;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SHIFT: begin
        if (walk_end) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer: status and RAM write port
  always_comb begin
    status    = ST_OK;
    ram_we    = 1'b0;
    ram_waddr = cmp_idx_q - IDX_W'(1);
    ram_wdata = ram_rdata;
    case (state_q)
      S_SHIFT: begin
        ram_we = cmp_vld_q;
      end
      S_DONE: begin
        case (req_q.op)
          OP_ADD: begin
            if (full_q) begin
              status = ST_FULL;
            end else if (nid_any_q) begin
              status = ST_DUP;
            end else begin
              ram_we    = load;
              ram_waddr = count_q[IDX_W-1:0];
              ram_wdata = new_entry;
            end
          end
          OP_UPDATE: begin
            if (!key_found_q) begin
              status = ST_MISSING;
            end else if (clash_q) begin
              status = ST_DUP;
            end else begin
              ram_we    = load;
              ram_waddr = key_idx_q;
              ram_wdata = new_entry;
            end
          end
          OP_DELETE, OP_GET: begin
            if (!key_found_q) begin
              status = ST_MISSING;
            end
          end
          default: status = ST_OK;
        endcase
      end
      default: ram_we = 1'b0;
    endcase
  end

  // datapath registers
  always_comb begin
    req_d       = req_q;
    count_d     = count_q;
    cap_d       = cap_q;
    rd_idx_d    = rd_idx_q;
    cmp_vld_d   = issue;
    cmp_idx_d   = rd_idx_q[IDX_W-1:0];
    full_d      = full_q;
    key_found_d = key_found_q;
    key_idx_d   = key_idx_q;
    nid_any_d   = nid_any_q;
    clash_d     = clash_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_word_d  = out_word_q;

    if (cfg_we_i) begin
      if (int'(cfg_wdata_i) > CAPACITY) begin
        cap_d = CNT_W'(CAPACITY);
      end else begin
        cap_d = CNT_W'(cfg_wdata_i);
      end
    end

    if (accept) begin
      req_d       = in_word_i;
      rd_idx_d    = '0;
      full_d      = (in_word_i.op == OP_ADD) && (count_q >= cap_q);
      key_found_d = 1'b0;
      key_idx_d   = '0;
      nid_any_d   = 1'b0;
      clash_d     = 1'b0;
    end

    if (issue) begin
      rd_idx_d = rd_idx_q + CNT_W'(1);
    end

    if (state_q == S_SCAN) begin
      if (first_hit) begin
        key_found_d = 1'b1;
        key_idx_d   = cmp_idx_q;
        hit_d       = ram_rdata;
      end
      if (nid_hit) begin
        nid_any_d = 1'b1;
      end
      // a match on the entry being updated is its own id, not a clash
      if (nid_hit && !first_hit) begin
        clash_d = 1'b1;
      end
      if (walk_end) begin
        // shift starts reading just past the deleted entry
        rd_idx_d = CNT_W'(first_hit ? cmp_idx_q : key_idx_q) + CNT_W'(1);
      end
    end

    if (load) begin
      out_valid_d        = 1'b1;
      out_word_d.status  = status;
      out_word_d.found_id    = '0;
      out_word_d.found_value = '0;
      if ((req_q.op == OP_GET) && key_found_q) begin
        out_word_d.found_id    = hit_q[ENTRY_W-1 -: ID_BITS];
        out_word_d.found_value = PORT_VAL_BITS'(hit_q[VALUE_BITS-1:0]);
      end
      if ((req_q.op == OP_ADD) && (status == ST_OK)) begin
        count_d = count_q + CNT_W'(1);
      end
      if ((req_q.op == OP_DELETE) && (status == ST_OK)) begin
        count_d = count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cap_q       <= CNT_W'(MAX_RESET);
      rd_idx_q    <= '0;
      cmp_vld_q   <= 1'b0;
      full_q      <= 1'b0;
      key_found_q <= 1'b0;
      nid_any_q   <= 1'b0;
      clash_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cap_q       <= cap_d;
      rd_idx_q    <= rd_idx_d;
      cmp_vld_q   <= cmp_vld_d;
      full_q      <= full_d;
      key_found_q <= key_found_d;
      nid_any_q   <= nid_any_d;
      clash_q     <= clash_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    cmp_idx_q  <= cmp_idx_d;
    key_idx_q  <= key_idx_d;
    hit_q      <= hit_d;
    out_word_q <= out_word_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  `ASSERT_ALWAYS(a_count_in_range, clk_i, !rst_ni || (count_q <= CNT_W'(CAPACITY)))
  `ASSERT_RST(a_count_moves_on_done, clk_i, rst_ni,
              !$stable(count_q) |-> $past(state_q == S_DONE))
  `ASSERT_RST(a_result_from_done, clk_i, rst_ni,
              $rose(out_valid_q) |-> $past(state_q == S_DONE))
  `ASSERT_RST(a_shift_only_on_delete_hit, clk_i, rst_ni,
              (state_q == S_SHIFT) |-> (key_found_q && (req_q.op == OP_DELETE)))
  `ASSERT_RST(a_write_inside_table, clk_i, rst_ni,
              ram_we |-> (CNT_W'(ram_waddr) <= count_q))

endmodule

[tb/tb_keyed_entry_table.sv]
module tb_keyed_entry_table;
  timeunit 1ns;
  timeprecision 1ps;

  import kt_pkg::*;

  localparam int IDLE_PCT   = 19;
  localparam int STUCK_MAX  = 5000;
  localparam int POOL_DEPTH = 512;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  kt_in_t              in_word_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  kt_out_t             out_word_o;
  logic                cfg_we_i    = 1'b0;
  logic [CFG_BITS-1:0] cfg_wdata_i = '0;

  keyed_entry_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow copy of the table, updated as each request word is taken
  logic [ID_BITS-1:0]    tbl_id  [CAPACITY];
  logic [VALUE_BITS-1:0] tbl_val [CAPACITY];
  int                    tbl_n      = 0;
  int                    cap_in_use = MAX_RESET;

  kt_in_t  pending_reqs[$];
  kt_out_t results_due[$];
  kt_out_t predicted;
  kt_out_t want;

  logic [ID_BITS-1:0] id_pool [POOL_DEPTH];
  bit  no_gaps = 1'b0;
  int  mismatches = 0;
  int  results_seen = 0;
  int  stuck_cycles = 0;
  int  status_tally [4] = '{default: 0};
  int  op_tally [4] = '{default: 0};

  function automatic int find_slot(logic [ID_BITS-1:0] id);
    for (int i = 0; i < tbl_n; i++) begin
      if (tbl_id[i] == id) return i;
    end
    return tbl_n;
  endfunction

  function automatic kt_out_t apply_request(kt_in_t rq);
    kt_out_t res;
    int      hit;
    bit      clash;
    res = '0;
    res.status = ST_OK;
    hit = find_slot(rq.key);
    case (rq.op)
      OP_ADD: begin
        if (tbl_n >= cap_in_use) begin
          res.status = ST_FULL;
        end else if (find_slot(rq.entry_id) < tbl_n) begin
          res.status = ST_DUP;
        end else begin
          tbl_id[tbl_n]  = rq.entry_id;
          tbl_val[tbl_n] = rq.entry_value[VALUE_BITS-1:0];
          tbl_n++;
        end
      end
      OP_DELETE: begin
        if (hit >= tbl_n) begin
          res.status = ST_MISSING;
        end else begin
          for (int j = hit; j + 1 < tbl_n; j++) begin
            tbl_id[j]  = tbl_id[j+1];
            tbl_val[j] = tbl_val[j+1];
          end
          tbl_n--;
        end
      end
      OP_UPDATE: begin
        if (hit >= tbl_n) begin
          res.status = ST_MISSING;
        end else begin
          clash = 1'b0;
          for (int j = 0; j < tbl_n; j++) begin
            if (j != hit && tbl_id[j] == rq.entry_id) clash = 1'b1;
          end
          if (clash) begin
            res.status = ST_DUP;
          end else begin
            tbl_id[hit]  = rq.entry_id;
            tbl_val[hit] = rq.entry_value[VALUE_BITS-1:0];
          end
        end
      end
      default: begin
        if (hit >= tbl_n) begin
          res.status = ST_MISSING;
        end else begin
          res.found_id    = tbl_id[hit];
          res.found_value = tbl_val[hit];
        end
      end
    endcase
    return res;
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predicted = apply_request(in_word_i);
        results_due.push_back(predicted);
        status_tally[predicted.status]++;
        op_tally[in_word_i.op]++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_reqs.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
          in_word_i  <= pending_reqs.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: status %0d id %h value %h",
                     out_word_o.status, out_word_o.found_id, out_word_o.found_value);
        end else begin
          want = results_due.pop_front();
          if (out_word_o.status !== want.status || out_word_o.found_id !== want.found_id ||
              out_word_o.found_value !== want.found_value) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected status %0d id %h value %h, got %0d %h %h",
                       results_seen, want.status, want.found_id, want.found_value,
                       out_word_o.status, out_word_o.found_id, out_word_o.found_value);
          end
        end
      end
      out_stall_i <= !no_gaps && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_MAX) begin
      $display("no word moved for %0d cycles", STUCK_MAX);
      $display("FAIL keyed_entry_table");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic push_req(kt_op_e op, logic [31:0] key, logic [31:0] id, logic [63:0] val);
    kt_in_t rq;
    rq.op          = op;
    rq.key         = key;
    rq.entry_id    = id;
    rq.entry_value = val;
    pending_reqs.push_back(rq);
  endtask

  // ids mostly from id_pool[lo..hi-1]; with fresh_adds set, each add takes
  // the next unused pool id while the pool lasts, so the table fills up
  task automatic queue_requests(int n, int pct_add, int pct_del, int pct_upd,
                                int lo, int hi, bit fresh_adds);
    kt_op_e      op;
    logic [31:0] key;
    logic [31:0] id;
    logic [63:0] val;
    int          r;
    for (int k = 0; k < n; k++) begin
      r  = $urandom_range(99);
      if (r < pct_add) begin
        op = OP_ADD;
      end else if (r < pct_add + pct_del) begin
        op = OP_DELETE;
      end else if (r < pct_add + pct_del + pct_upd) begin
        op = OP_UPDATE;
      end else begin
        op = OP_GET;
      end
      key = (hi > lo && $urandom_range(9) != 0) ? id_pool[$urandom_range(hi - 1, lo)]
                                                : $urandom;
      if (op == OP_ADD && fresh_adds && hi < POOL_DEPTH) begin
        id = id_pool[hi];
        hi++;
      end else if (op == OP_UPDATE && $urandom_range(4) == 0) begin
        id = key;
      end else begin
        id = (hi > lo && $urandom_range(9) != 0) ? id_pool[$urandom_range(hi - 1, lo)]
                                                 : $urandom;
      end
      r   = $urandom_range(9);
      val = (r == 0) ? '0 : (r == 1) ? '1 : {$urandom, $urandom};
      push_req(op, key, id, val);
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_reqs.size() != 0 || in_valid_i || results_due.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_capacity(int v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v[CFG_BITS-1:0];
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cap_in_use = (v > CAPACITY) ? CAPACITY : v;
  endtask

  initial begin
    id_pool[0] = 32'h8000_0000;
    id_pool[1] = 32'h7fff_ffff;
    id_pool[2] = 32'h0000_0000;
    id_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < POOL_DEPTH; i++) id_pool[i] = $urandom;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: empty table, id extremes, clash and own-id rewrite, shifts
    push_req(OP_GET,    32'h0, 32'h0, '0);
    push_req(OP_DELETE, 32'h5, 32'h0, '0);
    push_req(OP_UPDATE, 32'h5, 32'h6, '1);
    push_req(OP_ADD,    32'h0, 32'h8000_0000, 64'h0);
    push_req(OP_ADD,    32'h0, 32'h7fff_ffff, '1);
    push_req(OP_ADD,    32'h0, 32'h0, 64'h5555_5555_5555_5555);
    push_req(OP_ADD,    32'h0, 32'hffff_ffff, 64'haaaa_aaaa_aaaa_aaaa);
    push_req(OP_ADD,    32'h0, 32'h7fff_ffff, 64'h1);
    push_req(OP_GET,    32'h8000_0000, 32'h0, '0);
    push_req(OP_GET,    32'hffff_ffff, 32'h0, '0);
    push_req(OP_UPDATE, 32'h0, 32'h7fff_ffff, 64'h2);
    push_req(OP_UPDATE, 32'h0, 32'h0, 64'h0123_4567_89ab_cdef);
    push_req(OP_UPDATE, 32'hffff_ffff, 32'h1234_5678, 64'hfedc_ba98_7654_3210);
    push_req(OP_GET,    32'h0, 32'h0, '0);
    push_req(OP_DELETE, 32'h8000_0000, 32'h0, '0);
    push_req(OP_GET,    32'h7fff_ffff, 32'h0, '0);
    push_req(OP_GET,    32'h1234_5678, 32'h0, '0);
    push_req(OP_DELETE, 32'h1234_5678, 32'h0, '0);
    push_req(OP_GET,    32'h8000_0000, 32'h0, '0);
    push_req(OP_DELETE, 32'h8000_0000, 32'h0, '0);
    wait_idle();

    set_capacity(4);
    queue_requests(150, 40, 20, 20, 0, 10, 1'b0);
    wait_idle();

    // capacity zero: every add is refused, lookups still see old entries
    set_capacity(0);
    queue_requests(30, 40, 10, 20, 0, 10, 1'b0);
    wait_idle();

    // above CAPACITY saturates; fill the table right up
    set_capacity(255);
    queue_requests(180, 85, 3, 5, 100, 100, 1'b0 | 1'b1);
    wait_idle();

    // capacity lowered below the count already held
    set_capacity(1);
    queue_requests(100, 10, 50, 15, 100, 250, 1'b0);
    wait_idle();

    no_gaps = 1'b1;
    set_capacity(16);
    queue_requests(120, 35, 20, 20, 0, 24, 1'b0);
    wait_idle();
    no_gaps = 1'b0;

    set_capacity(CAPACITY);
    queue_requests(200, 35, 20, 20, 0, 40, 1'b0);
    wait_idle();

    repeat (300) @(posedge clk_i);
    $display("%0d results checked: %0d add, %0d delete, %0d update, %0d get",
             results_seen, op_tally[OP_ADD], op_tally[OP_DELETE], op_tally[OP_UPDATE],
             op_tally[OP_GET]);
    $display("status seen: %0d ok, %0d full, %0d duplicate, %0d missing; %0d mismatches",
             status_tally[ST_OK], status_tally[ST_FULL], status_tally[ST_DUP],
             status_tally[ST_MISSING], mismatches);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("PASS keyed_entry_table");
    end else begin
      $display("FAIL keyed_entry_table");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/kt_pkg.sv
sv/kt_ram.sv
sv/keyed_entry_table.sv
tb/tb_keyed_entry_table.sv
